### src/ntc_pkg.sv
// Shared types, constants and the month table for the NTP timestamp converter.
// Used by ntc_div_cell, ntc_calendar and ntp_timestamp_to_calendar.
`timescale 1ns / 1ps

package ntc_pkg;

	localparam int DIV_STEPS = 32;
	localparam int CAL_LAT   = 5;
	localparam int DAY_LAT   = 2;

	localparam logic [0:0] REG_TIME_OFFSET = 1'b0;
	localparam logic [0:0] REG_TICKS_PER_SEC = 1'b1;

	localparam logic [7:0]  VERSION_MASK   = 8'h38;
	localparam logic [7:0]  VERSION_3      = 8'h18;
	localparam logic [31:0] NTP_UNIX_BASE  = 32'd2208988800;
	localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
	localparam logic [31:0] FRAC_FULL      = 32'hFFFF_FFFF;
	localparam logic [16:0] TPS_RESET      = 17'd100;
	localparam logic [31:0] SIGN_BIAS      = 32'h8000_0000;

	// Ceiling of 2^35 / 675. With the seven low bits of a 32-bit value dropped,
	// multiplying by this and keeping bits 50..35 divides exactly by 86400.
	localparam logic [25:0] DAY_RECIP      = 26'd50903317;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] quo;
	} div_t;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_t;

	// Day of the year (from 0) on which month m starts.
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

### src/ntc_div_cell.sv
// One restoring division step with its output register.
// Depends on ntc_pkg for the division word type.
`timescale 1ns / 1ps

module ntc_div_cell (
	input  logic          clk,
	input  ntc_pkg::div_t d_in,
	output ntc_pkg::div_t d_out
);

	logic [32:0]   trial;
	logic [33:0]   diff;
	ntc_pkg::div_t nxt;
	ntc_pkg::div_t cell_q;

	always_comb begin
		trial   = {d_in.rem, d_in.num[31]};
		diff    = {1'b0, trial} - {2'b00, d_in.den};
		nxt     = d_in;
		nxt.num = {d_in.num[30:0], 1'b0};
		if (!diff[33]) begin
			nxt.rem = diff[31:0];
			nxt.quo = {d_in.quo[30:0], 1'b1};
		end else begin
			nxt.rem = trial[31:0];
			nxt.quo = {d_in.quo[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

	assign d_out = cell_q;

endmodule

### src/ntc_calendar.sv
// Five-stage pipeline from day quotient and remainder to calendar date and time of day.
// Depends on ntc_pkg for the calendar type and the month table.
`timescale 1ns / 1ps

module ntc_calendar (
	input  logic          clk,
	input  logic [15:0]   day_quo,
	input  logic [16:0]   day_rem,
	output ntc_pkg::cal_t cal
);

	// The input is the biased time divided by one day. The bias leaves 11648 s
	// over a whole number of days; n counts days from 1901-01-01.
	logic [15:0] n_s1, n_s2;
	logic [16:0] sod_s1, sod_s2;
	logic [37:0] qprod, hprod;
	logic [5:0]  qq_s2, qq_s3;
	logic [4:0]  hr_s2, hr_s3, hr_s4;
	logic [10:0] r4_s3;
	logic [11:0] sh_s3, sh_s4;
	logic [1:0]  y4;
	logic [8:0]  doy_s4;
	logic [10:0] year_s4;
	logic        leap_s4;
	logic [26:0] mprod;
	logic [5:0]  mn_s4;
	logic [3:0]  mon;
	logic [8:0]  mst;
	ntc_pkg::cal_t cal_s5;

	always_ff @(posedge clk) begin
		if (day_rem >= 17'd11648) begin
			n_s1   <= day_quo + 16'd347;
			sod_s1 <= day_rem - 17'd11648;
		end else begin
			n_s1   <= day_quo + 16'd346;
			sod_s1 <= day_rem + 17'd74752;
		end
	end

	// Four-year groups and hours by reciprocal multiplication.
	assign qprod = 38'(n_s1) * 38'd2939745;
	assign hprod = 38'(sod_s1) * 38'd1193047;

	always_ff @(posedge clk) begin
		qq_s2  <= qprod[37:32];
		hr_s2  <= hprod[36:32];
		n_s2   <= n_s1;
		sod_s2 <= sod_s1;
	end

	always_ff @(posedge clk) begin
		r4_s3 <= 11'(n_s2 - 16'(qq_s2) * 16'd1461);
		sh_s3 <= 12'(sod_s2 - 17'(hr_s2) * 17'd3600);
		qq_s3 <= qq_s2;
		hr_s3 <= hr_s2;
	end

	// Within 1901..2038 every fourth year is a leap year, the last of its group.
	always_comb begin
		if (r4_s3 >= 11'd1095) begin
			y4 = 2'd3;
		end else if (r4_s3 >= 11'd730) begin
			y4 = 2'd2;
		end else if (r4_s3 >= 11'd365) begin
			y4 = 2'd1;
		end else begin
			y4 = 2'd0;
		end
	end

	assign mprod = 27'(sh_s3) * 27'd17477;

	always_ff @(posedge clk) begin
		doy_s4  <= 9'(r4_s3 - 11'(y4) * 11'd365);
		year_s4 <= 11'd1901 + 11'({qq_s3, 2'b00}) + 11'(y4);
		leap_s4 <= (y4 == 2'd3);
		mn_s4   <= mprod[25:20];
		sh_s4   <= sh_s3;
		hr_s4   <= hr_s3;
	end

	always_comb begin
		mon = 4'd1;
		mst = 9'd0;
		for (int k = 2; k <= 12; k++) begin
			if (doy_s4 >= ntc_pkg::month_start(4'(k), leap_s4)) begin
				mon = 4'(k);
				mst = ntc_pkg::month_start(4'(k), leap_s4);
			end
		end
	end

	always_ff @(posedge clk) begin
		cal_s5.year   <= year_s4;
		cal_s5.month  <= mon;
		cal_s5.day    <= 5'(doy_s4 - mst + 9'd1);
		cal_s5.hour   <= hr_s4;
		cal_s5.minute <= mn_s4;
		cal_s5.second <= 6'(sh_s4 - 12'(mn_s4) * 12'd60);
	end

	assign cal = cal_s5;

endmodule

### src/ntp_timestamp_to_calendar.sv
// Top level of the NTP transmit timestamp to UTC calendar converter.
// Depends on ntc_pkg, ntc_div_cell and ntc_calendar.
`timescale 1ns / 1ps

// The converter takes one timestamp word in every clock cycle and never stalls:
// busy is always low, and each word returns exactly one result word. Done is
// high for a single cycle once the word has passed the input register, both
// rows of cells and the output register, and the result is shown while done is
// high. Results leave in the order the words came in, and the receiver must take
// each one in the cycle it is shown. The word passes through two rows of 32
// division cells, one quotient bit per cell: the first row divides the full
// fraction by the tick rate to get the step size, and the second row divides the
// fraction by that step size. The division of the time by one day is a two-stage
// reciprocal multiplication, and the calendar pipeline follows it; their result
// is delayed to line up with the end of the second row. A word whose version
// field is not 3, or whose seconds and fraction are both zero, gives accepted
// low and all other fields zero. The two registers may be written only while
// no word is in flight.
module ntp_timestamp_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  mode_byte,
	input  logic [31:0] stamp_seconds,
	input  logic [31:0] stamp_fraction,
	input  logic        wr_en,
	input  logic [0:0]  wr_idx,
	input  logic [17:0] wr_data,
	output logic        done,
	output logic        accepted,
	output logic [10:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [16:0] ticks
);

	localparam int STEPS = ntc_pkg::DIV_STEPS;
	localparam int CAL_DELAY = 2 * ntc_pkg::DIV_STEPS - ntc_pkg::DAY_LAT - ntc_pkg::CAL_LAT;

	// Configuration registers.
	logic [17:0] offset_q;
	logic [16:0] tps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			tps_q    <= ntc_pkg::TPS_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				ntc_pkg::REG_TIME_OFFSET:   offset_q <= wr_data;
				ntc_pkg::REG_TICKS_PER_SEC: tps_q    <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic        take;
	logic        good;
	logic [31:0] unix_u;

	assign take   = start && !busy;
	assign good   = ((mode_byte & ntc_pkg::VERSION_MASK) == ntc_pkg::VERSION_3) &&
			!(stamp_seconds == 32'd0 && stamp_fraction == 32'd0);
	assign unix_u = stamp_seconds - ntc_pkg::NTP_UNIX_BASE - {{14{offset_q[17]}}, offset_q};

	// Side data that travels with the first row of cells. Element 0 is the
	// input register; flipping the sign bit makes the signed time non-negative.
	logic        vld_a_q  [0:STEPS];
	logic        acc_a_q  [0:STEPS];
	logic [31:0] ain_q;
	logic [31:0] frac_a_q [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q[0] <= 1'b0;
		end else begin
			vld_a_q[0] <= take;
		end
	end

	always_ff @(posedge clk) begin
		acc_a_q[0]  <= good;
		ain_q       <= unix_u ^ ntc_pkg::SIGN_BIAS;
		frac_a_q[0] <= stamp_fraction;
	end

	ntc_pkg::div_t divy [0:STEPS];
	ntc_pkg::div_t divb [0:STEPS];

	assign divy[0] = '{rem: 32'd0, num: ntc_pkg::FRAC_FULL, den: {15'd0, tps_q}, quo: 32'd0};

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_row_a
			ntc_div_cell u_step_cell (.clk(clk), .d_in(divy[k]), .d_out(divy[k+1]));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_a_q[k+1] <= 1'b0;
				end else begin
					vld_a_q[k+1] <= vld_a_q[k];
				end
			end

			always_ff @(posedge clk) begin
				acc_a_q[k+1]  <= acc_a_q[k];
				frac_a_q[k+1] <= frac_a_q[k];
			end
		end
	endgenerate

	// Second row: fraction divided by the step size from the first row.
	assign divb[0] = '{rem: 32'd0, num: frac_a_q[STEPS], den: divy[STEPS].quo, quo: 32'd0};

	logic vld_b_q [1:STEPS];
	logic acc_b_q [1:STEPS];

	generate
		for (k = 0; k < STEPS; k++) begin : g_row_b
			ntc_div_cell u_tick_cell (.clk(clk), .d_in(divb[k]), .d_out(divb[k+1]));

			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_b_q[1] <= 1'b0;
					end else begin
						vld_b_q[1] <= vld_a_q[STEPS];
					end
				end

				always_ff @(posedge clk) begin
					acc_b_q[1] <= acc_a_q[STEPS];
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_b_q[k+1] <= 1'b0;
					end else begin
						vld_b_q[k+1] <= vld_b_q[k];
					end
				end

				always_ff @(posedge clk) begin
					acc_b_q[k+1] <= acc_b_q[k];
				end
			end
		end
	endgenerate

	// Day quotient of the biased time by reciprocal multiplication, then the
	// remainder from the quotient in the next stage.
	logic [50:0] day_prod;
	logic [15:0] day_quo_s1, day_quo_s2;
	logic [31:0] ain_s1;
	logic [16:0] day_rem_s2;

	assign day_prod = 51'(ain_q[31:7]) * 51'(ntc_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		day_quo_s1 <= day_prod[50:35];
		ain_s1     <= ain_q;
		day_quo_s2 <= day_quo_s1;
		day_rem_s2 <= 17'(ain_s1 - 32'(day_quo_s1) * ntc_pkg::SECS_PER_DAY);
	end

	// The calendar pipeline starts from the day quotient and remainder and its
	// result is delayed to line up with the end of the second row.
	ntc_pkg::cal_t cal_out;
	ntc_pkg::cal_t cal_d_q [1:CAL_DELAY];

	ntc_calendar u_calendar (
		.clk     (clk),
		.day_quo (day_quo_s2),
		.day_rem (day_rem_s2),
		.cal     (cal_out)
	);

	generate
		for (k = 1; k <= CAL_DELAY; k++) begin : g_cal_delay
			if (k == 1) begin : g_first
				always_ff @(posedge clk) begin
					cal_d_q[1] <= cal_out;
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					cal_d_q[k] <= cal_d_q[k-1];
				end
			end
		end
	endgenerate

	// Tick count, clamped below the tick rate; zero when that register is zero.
	logic [31:0] tick_quo;
	logic [16:0] tick_val;

	assign tick_quo = divb[STEPS].quo;

	always_comb begin
		if (tps_q == 17'd0) begin
			tick_val = 17'd0;
		end else if (tick_quo >= {15'd0, tps_q}) begin
			tick_val = tps_q - 17'd1;
		end else begin
			tick_val = tick_quo[16:0];
		end
	end

	// Output register.
	logic          done_q;
	logic          acc_q;
	ntc_pkg::cal_t res_q;
	logic [16:0]   ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_b_q[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_b_q[STEPS];
		if (acc_b_q[STEPS]) begin
			res_q   <= cal_d_q[CAL_DELAY];
			ticks_q <= tick_val;
		end else begin
			res_q   <= '0;
			ticks_q <= 17'd0;
		end
	end

	assign done     = done_q;
	assign accepted = done_q && acc_q;
	assign year     = res_q.year;
	assign month    = res_q.month;
	assign day      = res_q.day;
	assign hour     = res_q.hour;
	assign minute   = res_q.minute;
	assign second   = res_q.second;
	assign ticks    = ticks_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (year == 11'd0 && month == 4'd0 && day == 5'd0 &&
			hour == 5'd0 && minute == 6'd0 && second == 6'd0 && ticks == 17'd0))
		else $error("rejected word carries nonzero fields");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
			day <= 5'd31 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("calendar field out of range");

	a_tick_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted && tps_q != 17'd0) |-> (ticks < tps_q))
		else $error("tick count not below the tick rate");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		vld_a_q[0] |-> $past(start))
		else $error("word entered without start");

endmodule

### verif/ntc_checker.sv
// Checker for the NTP timestamp converter: predicts each result word from the
// accepted input words and the register writes, and compares. Depends on ntc_pkg.
`timescale 1ns / 1ps

module ntc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [7:0]  mode_byte,
	input  logic [31:0] stamp_seconds,
	input  logic [31:0] stamp_fraction,
	input  logic        wr_en,
	input  logic [0:0]  wr_idx,
	input  logic [17:0] wr_data,
	input  logic        done,
	input  logic        accepted,
	input  logic [10:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	input  logic [16:0] ticks,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic          ok;
		ntc_pkg::cal_t cal;
		logic [16:0]   tk;
	} date_word_t;

	date_word_t  date_queue[$];
	logic [17:0] offset_reg;
	logic [16:0] tps_reg;

	assign pending = date_queue.size();

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	function automatic date_word_t convert_stamp(logic [7:0] mb, logic [31:0] secs,
			logic [31:0] frac);
		date_word_t w;
		logic [31:0] off, u, step, q;
		longint t, days, sod, z, era, doe, yoe, y, doy, mp, d, m;
		w = '0;
		if ((mb & ntc_pkg::VERSION_MASK) != ntc_pkg::VERSION_3 || (secs == 0 && frac == 0))
			return w;
		off = {{14{offset_reg[17]}}, offset_reg};
		u = secs - ntc_pkg::NTP_UNIX_BASE - off;
		t = longint'($signed(u));
		days = floor_quot(t, 86400);
		sod = t - days * 86400;
		z = days + 719468;
		era = floor_quot(z, 146097);
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		if (m <= 2) y = y + 1;
		if (tps_reg != 0) begin
			step = ntc_pkg::FRAC_FULL / {15'd0, tps_reg};
			q = frac / step;
			if (q >= {15'd0, tps_reg}) q = {15'd0, tps_reg} - 1;
			w.tk = q[16:0];
		end
		w.ok = 1'b1;
		w.cal.year = y[10:0];
		w.cal.month = m[3:0];
		w.cal.day = d[4:0];
		w.cal.hour = 5'(sod / 3600);
		w.cal.minute = 6'((sod / 60) % 60);
		w.cal.second = 6'(sod % 60);
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		date_word_t w;
		if (!arst_n) begin
			offset_reg <= '0;
			tps_reg <= ntc_pkg::TPS_RESET;
			fail_count <= 0;
			date_queue.delete();
		end else begin
			if (done) begin
				if (date_queue.size() == 0) begin
					report_mismatch("unexpected result word", 1, 0);
				end else begin
					w = date_queue.pop_front();
					if (accepted !== w.ok) report_mismatch("accepted", accepted, w.ok);
					if (year !== w.cal.year) report_mismatch("year", year, w.cal.year);
					if (month !== w.cal.month) report_mismatch("month", month, w.cal.month);
					if (day !== w.cal.day) report_mismatch("day", day, w.cal.day);
					if (hour !== w.cal.hour) report_mismatch("hour", hour, w.cal.hour);
					if (minute !== w.cal.minute)
						report_mismatch("minute", minute, w.cal.minute);
					if (second !== w.cal.second)
						report_mismatch("second", second, w.cal.second);
					if (ticks !== w.tk) report_mismatch("ticks", ticks, w.tk);
				end
			end
			if (start && !busy)
				date_queue.push_back(convert_stamp(mode_byte, stamp_seconds, stamp_fraction));
			if (wr_en) begin
				if (wr_idx == ntc_pkg::REG_TIME_OFFSET) offset_reg <= wr_data;
				else tps_reg <= wr_data[16:0];
			end
		end
	end
endmodule

### verif/ntp_timestamp_to_calendar_tb.sv
// Testbench top for the NTP timestamp converter: makes stimulus and register
// writes and gives the verdict. Depends on ntc_pkg, ntc_checker and the block.
`timescale 1ns / 1ps

module ntp_timestamp_to_calendar_tb;

	// Cycles with no handshake before the run is declared hung. The limit lies far
	// above the time the block takes to answer a word and the longest sender gap.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  mode_byte = '0;
	logic [31:0] stamp_seconds = '0;
	logic [31:0] stamp_fraction = '0;
	logic        wr_en = 1'b0;
	logic [0:0]  wr_idx = ntc_pkg::REG_TIME_OFFSET;
	logic [17:0] wr_data = '0;
	logic        done, accepted;
	logic [10:0] year;
	logic [3:0]  month;
	logic [4:0]  day, hour;
	logic [5:0]  minute, second;
	logic [16:0] ticks;
	int          fail_count, pending;
	int          idle_cycles = 0;

	always #10 clk = ~clk;

	ntp_timestamp_to_calendar DUT (.*);

	ntc_checker checker_i (.*);

	// The watchdog counts cycles in which neither a word goes in nor a result
	// comes out; gaps and the end-of-run drain are far shorter than the limit.
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sender gap: mostly none or a few cycles, now and then a long one.
	function automatic int gap_len();
		return ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
			int'($urandom_range(10, 40));
	endfunction

	// Present one word and hold it until the block takes it. Start is dropped
	// only when a nonzero gap follows.
	task automatic send_stamp(logic [7:0] mb, logic [31:0] secs, logic [31:0] frac,
			bit gaps);
		int n;
		start <= 1'b1;
		mode_byte <= mb;
		stamp_seconds <= secs;
		stamp_fraction <= frac;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gaps && $urandom_range(0, 3) == 0) begin
			n = gap_len();
			if (n > 0) begin
				start <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only when nothing is in flight, so drain first.
	task automatic write_reg(logic [0:0] idx, logic [17:0] val);
		stop_sending();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Mode byte with version 3 and random leap and mode bits.
	function automatic logic [7:0] good_mode();
		logic [7:0] r;
		r = 8'($urandom);
		return (r & ~ntc_pkg::VERSION_MASK) | ntc_pkg::VERSION_3;
	endfunction

	// Seconds chosen mostly across the valid span, sometimes fully random.
	function automatic logic [31:0] pick_seconds();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return ntc_pkg::NTP_UNIX_BASE + $urandom_range(0, 200000) - 100000;
			2: return ntc_pkg::NTP_UNIX_BASE + 32'h7FFF_FFFF - $urandom_range(0, 200000);
			3: return ntc_pkg::NTP_UNIX_BASE + 32'h8000_0000 + $urandom_range(0, 200000);
			default: return ntc_pkg::NTP_UNIX_BASE + $urandom_range(0, 32'h7FFF_FFFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_fraction();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
			1: return $urandom_range(0, 1000);
			default: return $urandom;
		endcase
	endfunction

	// Run a random phase of n words, most of them well formed.
	task automatic random_phase(int n);
		logic [7:0] mb;
		repeat (n) begin
			mb = ($urandom_range(0, 9) < 8) ? good_mode() : 8'($urandom);
			if ($urandom_range(0, 39) == 0)
				send_stamp(mb, 32'd0, 32'd0, 1'b1);
			else
				send_stamp(mb, pick_seconds(), pick_fraction(), 1'b1);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers, version checks, all-zero stamp, calendar edges.
		send_stamp(8'h1B, 32'd0, 32'd0, 1'b0);           // all-zero stamp rejected
		send_stamp(8'h23, ntc_pkg::NTP_UNIX_BASE, 32'd1, 1'b0);   // version 4 rejected
		send_stamp(8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_stamp(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_stamp(8'hDF, 32'd0, 32'd1, 1'b0);           // seconds zero, fraction not
		send_stamp(8'h18, 32'd1, 32'd0, 1'b0);
		send_stamp(8'h1B, ntc_pkg::NTP_UNIX_BASE, 32'hFFFF_FFFF, 1'b0); // epoch, clamp
		send_stamp(8'hDC, ntc_pkg::NTP_UNIX_BASE - 32'd1, 32'h8000_0000, 1'b0);
		send_stamp(8'h1C, ntc_pkg::NTP_UNIX_BASE + 32'h7FFF_FFFF, 32'd0, 1'b1); // 2038
		send_stamp(8'h1C, ntc_pkg::NTP_UNIX_BASE + 32'h8000_0000, 32'd0, 1'b1); // 1901
		send_stamp(8'h1A, ntc_pkg::NTP_UNIX_BASE + 32'd951782400, 32'd5, 1'b1); // 2000-02-29
		send_stamp(8'h19, ntc_pkg::NTP_UNIX_BASE + 32'd1709251199, 32'd7, 1'b1);
		send_stamp(8'h1B, ntc_pkg::NTP_UNIX_BASE + 32'd4107542399, 32'd9, 1'b1);

		write_reg(ntc_pkg::REG_TIME_OFFSET, 18'sd86400);
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'd100000);
		send_stamp(8'h1B, ntc_pkg::NTP_UNIX_BASE, 32'hFFFF_FFFF, 1'b0);
		send_stamp(8'h1B, ntc_pkg::NTP_UNIX_BASE + 32'h8000_0000 + 32'd86400, 32'd12345,
			1'b0);
		random_phase(120);

		write_reg(ntc_pkg::REG_TIME_OFFSET, -18'sd86400);
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'd1);
		send_stamp(8'h1B, ntc_pkg::NTP_UNIX_BASE + 32'h7FFF_FFFF - 32'd86400, 32'hFFFF_FFFF,
			1'b0);
		random_phase(100);

		// Out-of-range register values: zero and oversized tick rates, full-width offset.
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'd0);
		write_reg(ntc_pkg::REG_TIME_OFFSET, 18'h3FFFF);
		random_phase(60);
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'h1FFFF);
		write_reg(ntc_pkg::REG_TIME_OFFSET, 18'h1FFFF);
		random_phase(60);
		write_reg(ntc_pkg::REG_TIME_OFFSET, 18'h20000);
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'h3FFFF);
		random_phase(60);

		write_reg(ntc_pkg::REG_TIME_OFFSET, 18'($urandom_range(0, 172800) - 86400));
		write_reg(ntc_pkg::REG_TICKS_PER_SEC, 18'($urandom_range(1, 100000)));
		random_phase(150);

		stop_sending();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
